### hw/rtl/rrqs_pkg.sv
// shared constants, codes and types of the round-robin quantum scheduler
package rrqs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int LIVE_W    = 5;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LINK = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tm;
    } t_payload;

    typedef struct packed {
        logic             set_en;
        logic [IDX_W-1:0] set_idx;
        logic             clr_en;
        logic [IDX_W-1:0] clr_idx;
    } t_slot_cmd;

endpackage

### hw/rtl/rrqs_ram.sv
// generic single-port-write, registered-read memory
module rrqs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/rrqs_slot_map.sv
// occupancy bits of the slots and lowest-free-slot encoder
module rrqs_slot_map (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rrqs_pkg::t_slot_cmd       i_cmd,
    output logic [rrqs_pkg::IDX_W-1:0] o_free_idx
);

    logic [rrqs_pkg::MAX_PROCS-1:0] r_used;
    logic [rrqs_pkg::MAX_PROCS-1:0] n_used;
    logic [rrqs_pkg::IDX_W-1:0]     free_idx;

    always_comb begin
        n_used = r_used;
        if (i_cmd.clr_en) begin
            n_used[i_cmd.clr_idx] = 1'b0;
        end
        if (i_cmd.set_en) begin
            n_used[i_cmd.set_idx] = 1'b1;
        end
    end

    // scan downward so the lowest free slot wins
    always_comb begin
        free_idx = '0;
        for (int i = rrqs_pkg::MAX_PROCS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = rrqs_pkg::IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    assign o_free_idx = free_idx;

endmodule

### hw/rtl/round_robin_quantum_scheduler.sv
// round-robin time-slice scheduler: control, pointers and the two list memories
//
// Keeps up to 16 processes in a circular run list held in two memories (id and
// remaining time per slot, and the successor link per slot); the head, tail,
// cursor and its predecessor live in registers. An item is taken when start is
// high and busy is low. A run item goes through S_RUN, as the memories have a
// registered read: the slot under the cursor is read, then the time is written
// back or the slot is unlinked. An add on an empty list is done from idle;
// otherwise it goes through S_LINK, which writes the old tail's link through
// the single write port of the link memory. A rejected add and a run on an
// empty list are answered from idle. The result shows on the o_ ports for
// exactly one cycle, marked by o_valid, in the cycle after the item's last
// cycle (accepting or last busy cycle); the receiver cannot stall, so a result
// must be captured then. The quantum register is written through i_cfg_we and
// i_cfg_wdata and resets to 1; write it only while no item is in flight.
module round_robin_quantum_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrqs_pkg::TIME_W-1:0]       i_cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic [rrqs_pkg::ID_W-1:0]         i_proc_id,
    input  logic [rrqs_pkg::TIME_W-1:0]       i_exec_time,
    output logic                              o_valid,
    output logic [rrqs_pkg::STATUS_W-1:0]     o_status,
    output logic [rrqs_pkg::ID_W-1:0]         o_ran_id,
    output logic [rrqs_pkg::TIME_W-1:0]       o_time_before,
    output logic                              o_completed,
    output logic [rrqs_pkg::LIVE_W-1:0]       o_live_count
);

    rrqs_pkg::t_state r_state, n_state;

    logic [rrqs_pkg::IDX_W-1:0] r_head, n_head;
    logic [rrqs_pkg::IDX_W-1:0] r_tail, n_tail;
    logic [rrqs_pkg::IDX_W-1:0] r_cur,  n_cur;
    logic [rrqs_pkg::IDX_W-1:0] r_prev, n_prev;
    logic [rrqs_pkg::CNT_W-1:0] r_count, n_count;
    logic [rrqs_pkg::TIME_W-1:0] r_quantum;

    logic [rrqs_pkg::IDX_W-1:0] r_fix_addr, n_fix_addr;
    logic [rrqs_pkg::IDX_W-1:0] r_fix_data, n_fix_data;

    logic                          r_valid, n_valid;
    logic [rrqs_pkg::STATUS_W-1:0] r_status, n_status;
    logic [rrqs_pkg::ID_W-1:0]     r_ran_id, n_ran_id;
    logic [rrqs_pkg::TIME_W-1:0]   r_time_before, n_time_before;
    logic                          r_completed, n_completed;
    logic [rrqs_pkg::LIVE_W-1:0]   r_live_count, n_live_count;

    logic                       pay_we;
    logic [rrqs_pkg::IDX_W-1:0] pay_waddr;
    rrqs_pkg::t_payload         pay_wdata;
    rrqs_pkg::t_payload         pay_rdata;

    logic                       link_we;
    logic [rrqs_pkg::IDX_W-1:0] link_waddr;
    logic [rrqs_pkg::IDX_W-1:0] link_wdata;
    logic [rrqs_pkg::IDX_W-1:0] link_rdata;

    rrqs_pkg::t_slot_cmd        slot_cmd;
    logic [rrqs_pkg::IDX_W-1:0] free_idx;

    logic accept;
    logic run_done;

    assign accept   = start && !busy;
    assign busy     = (r_state != rrqs_pkg::S_IDLE);
    assign run_done = (pay_rdata.tm <= r_quantum);

    rrqs_ram #(
        .DEPTH (rrqs_pkg::MAX_PROCS),
        .WIDTH ($bits(rrqs_pkg::t_payload))
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (pay_wdata),
        .i_raddr (r_cur),
        .o_rdata (pay_rdata)
    );

    rrqs_ram #(
        .DEPTH (rrqs_pkg::MAX_PROCS),
        .WIDTH (rrqs_pkg::IDX_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (r_cur),
        .o_rdata (link_rdata)
    );

    rrqs_slot_map u_slot_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (slot_cmd),
        .o_free_idx (free_idx)
    );

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_count       = r_count;
        n_fix_addr    = r_fix_addr;
        n_fix_data    = r_fix_data;
        n_valid       = 1'b0;
        n_status      = rrqs_pkg::ST_OK;
        n_ran_id      = '0;
        n_time_before = '0;
        n_completed   = 1'b0;
        n_live_count  = rrqs_pkg::LIVE_W'(r_count);
        pay_we        = 1'b0;
        pay_waddr     = free_idx;
        pay_wdata     = '{id: i_proc_id, tm: i_exec_time};
        link_we       = 1'b0;
        link_waddr    = free_idx;
        link_wdata    = r_head;
        slot_cmd      = '0;

        unique case (r_state)
            rrqs_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_command == rrqs_pkg::CMD_ADD) begin
                        if (r_count == rrqs_pkg::CNT_W'(rrqs_pkg::MAX_PROCS)) begin
                            n_valid  = 1'b1;
                            n_status = rrqs_pkg::ST_FULL;
                        end else begin
                            pay_we           = 1'b1;
                            link_we          = 1'b1;
                            slot_cmd.set_en  = 1'b1;
                            slot_cmd.set_idx = free_idx;
                            n_count          = r_count + rrqs_pkg::CNT_W'(1);
                            if (r_count == '0) begin
                                // first process links to itself
                                link_wdata   = free_idx;
                                n_head       = free_idx;
                                n_tail       = free_idx;
                                n_cur        = free_idx;
                                n_prev       = free_idx;
                                n_valid      = 1'b1;
                                n_live_count = rrqs_pkg::LIVE_W'(n_count);
                            end else begin
                                if (r_cur == r_head) begin
                                    n_prev = free_idx;
                                end
                                n_tail     = free_idx;
                                n_fix_addr = r_tail;
                                n_fix_data = free_idx;
                                n_state    = rrqs_pkg::S_LINK;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = rrqs_pkg::ST_EMPTY;
                        end else begin
                            n_state = rrqs_pkg::S_RUN;
                        end
                    end
                end
            end
            rrqs_pkg::S_LINK: begin
                // old tail now points at the new slot
                link_we    = 1'b1;
                link_waddr = r_fix_addr;
                link_wdata = r_fix_data;
                n_valid    = 1'b1;
                n_state    = rrqs_pkg::S_IDLE;
            end
            rrqs_pkg::S_RUN: begin
                n_valid       = 1'b1;
                n_ran_id      = pay_rdata.id;
                n_time_before = pay_rdata.tm;
                n_completed   = run_done;
                if (run_done) begin
                    slot_cmd.clr_en  = 1'b1;
                    slot_cmd.clr_idx = r_cur;
                    n_count          = r_count - rrqs_pkg::CNT_W'(1);
                    if (r_count == rrqs_pkg::CNT_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                        n_cur  = '0;
                        n_prev = '0;
                    end else begin
                        // unlink the served slot
                        link_we    = 1'b1;
                        link_waddr = r_prev;
                        link_wdata = link_rdata;
                        if (r_cur == r_head) begin
                            n_head = link_rdata;
                        end
                        if (r_cur == r_tail) begin
                            n_tail = r_prev;
                        end
                        n_cur = link_rdata;
                    end
                end else begin
                    pay_we    = 1'b1;
                    pay_waddr = r_cur;
                    pay_wdata = '{id: pay_rdata.id, tm: pay_rdata.tm - r_quantum};
                    n_prev    = r_cur;
                    n_cur     = link_rdata;
                end
                n_live_count = rrqs_pkg::LIVE_W'(n_count);
                n_state      = rrqs_pkg::S_IDLE;
            end
            default: begin
                n_state = rrqs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rrqs_pkg::S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_cur     <= '0;
            r_prev    <= '0;
            r_count   <= '0;
            r_quantum <= rrqs_pkg::TIME_W'(1);
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fix_addr    <= n_fix_addr;
        r_fix_data    <= n_fix_data;
        r_status      <= n_status;
        r_ran_id      <= n_ran_id;
        r_time_before <= n_time_before;
        r_completed   <= n_completed;
        r_live_count  <= n_live_count;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_ran_id      = r_ran_id;
    assign o_time_before = r_time_before;
    assign o_completed   = r_completed;
    assign o_live_count  = r_live_count;

endmodule

### hw/rtl/rrqs_checker.sv
// port-level checks of the round-robin quantum scheduler and their bind
module rrqs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrqs_pkg::TIME_W-1:0]       i_cfg_wdata,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              i_command,
    input  logic [rrqs_pkg::ID_W-1:0]         i_proc_id,
    input  logic [rrqs_pkg::TIME_W-1:0]       i_exec_time,
    input  logic                              o_valid,
    input  logic [rrqs_pkg::STATUS_W-1:0]     o_status,
    input  logic [rrqs_pkg::ID_W-1:0]         o_ran_id,
    input  logic [rrqs_pkg::TIME_W-1:0]       o_time_before,
    input  logic                              o_completed,
    input  logic [rrqs_pkg::LIVE_W-1:0]       o_live_count
);

    // every transaction either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted transaction neither answered nor busy");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rrqs_pkg::ST_FULL)
            |-> (o_live_count == rrqs_pkg::LIVE_W'(rrqs_pkg::MAX_PROCS)))
        else $error("full rejection with list not full");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rrqs_pkg::ST_EMPTY)
            |-> (o_live_count == '0 && o_ran_id == '0 && o_time_before == '0
                 && !o_completed))
        else $error("empty run result carries data");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_live_count <= rrqs_pkg::LIVE_W'(rrqs_pkg::MAX_PROCS)))
        else $error("live count above capacity");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (.*);

### bench/round_robin_quantum_scheduler_tb.sv
// self-checking testbench of the round-robin quantum scheduler
`timescale 1ns / 1ps

module round_robin_quantum_scheduler_tb;
    import rrqs_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_LIMIT = 200;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     ran_id;
        logic [TIME_W-1:0]   time_before;
        logic                completed;
        logic [LIVE_W-1:0]   live_count;
    } t_sched_outcome;

    // mirror of the circular run list plus the queue of outcomes still to arrive
    class t_run_list_board;
        logic [ID_W-1:0]   id_mem[MAX_PROCS];
        logic [TIME_W-1:0] left_mem[MAX_PROCS];
        logic [IDX_W-1:0]  link_mem[MAX_PROCS];
        bit                used[MAX_PROCS];
        logic [IDX_W-1:0]  head, tail, cur, prev;
        int                live;
        logic [TIME_W-1:0] quantum;
        t_sched_outcome    awaited_outcomes[$];
        int                errors;

        function new();
            for (int i = 0; i < MAX_PROCS; i++) begin
                used[i] = 1'b0;
            end
            head = '0;
            tail = '0;
            cur = '0;
            prev = '0;
            live = 0;
            quantum = 16'd1;
            errors = 0;
        endfunction

        function t_sched_outcome predict_outcome(logic cmd, logic [ID_W-1:0] pid,
                                                 logic [TIME_W-1:0] exec_tm);
            t_sched_outcome   o;
            int               slot;
            logic [IDX_W-1:0] c;
            logic [IDX_W-1:0] succ;
            logic [IDX_W-1:0] s;
            logic [TIME_W-1:0] t;
            o = '0;
            o.status = ST_OK;
            if (cmd == CMD_ADD) begin
                if (live >= MAX_PROCS) begin
                    o.status = ST_FULL;
                end else begin
                    slot = 0;
                    while (slot < MAX_PROCS && used[slot]) slot++;
                    s = IDX_W'(slot);
                    id_mem[s] = pid;
                    left_mem[s] = exec_tm;
                    used[s] = 1'b1;
                    if (live == 0) begin
                        link_mem[s] = s;
                        head = s;
                        tail = s;
                        cur = s;
                        prev = s;
                    end else begin
                        // append between tail and head
                        link_mem[tail] = s;
                        link_mem[s] = head;
                        if (cur == head) prev = s;
                        tail = s;
                    end
                    live++;
                end
            end else if (live == 0) begin
                o.status = ST_EMPTY;
            end else begin
                c = cur;
                t = left_mem[c];
                succ = link_mem[c];
                o.ran_id = id_mem[c];
                o.time_before = t;
                if (t <= quantum) begin
                    o.completed = 1'b1;
                    used[c] = 1'b0;
                    live--;
                    if (live == 0) begin
                        head = '0;
                        tail = '0;
                        cur = '0;
                        prev = '0;
                    end else begin
                        link_mem[prev] = succ;
                        if (c == head) head = succ;
                        if (c == tail) tail = prev;
                        cur = succ;
                    end
                end else begin
                    left_mem[c] = t - quantum;
                    prev = c;
                    cur = succ;
                end
            end
            o.live_count = LIVE_W'(live);
            return o;
        endfunction

        function void note_command(logic cmd, logic [ID_W-1:0] pid,
                                   logic [TIME_W-1:0] exec_tm);
            awaited_outcomes.push_back(predict_outcome(cmd, pid, exec_tm));
        endfunction

        task report_mismatch(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_outcome(t_sched_outcome got);
            t_sched_outcome want;
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = awaited_outcomes.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.ran_id !== want.ran_id)
                    report_mismatch($sformatf("ran_id %0d, want %0d", got.ran_id, want.ran_id));
                if (got.time_before !== want.time_before)
                    report_mismatch($sformatf("time_before %0d, want %0d",
                                              got.time_before, want.time_before));
                if (got.completed !== want.completed)
                    report_mismatch($sformatf("completed %0d, want %0d",
                                              got.completed, want.completed));
                if (got.live_count !== want.live_count)
                    report_mismatch($sformatf("live_count %0d, want %0d",
                                              got.live_count, want.live_count));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [TIME_W-1:0]   i_cfg_wdata;
    logic                start;
    logic                busy;
    logic                i_command;
    logic [ID_W-1:0]     i_proc_id;
    logic [TIME_W-1:0]   i_exec_time;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_ran_id;
    logic [TIME_W-1:0]   o_time_before;
    logic                o_completed;
    logic [LIVE_W-1:0]   o_live_count;

    t_run_list_board board;
    int              idle_cycles = 0;

    round_robin_quantum_scheduler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_proc_id     (i_proc_id),
        .i_exec_time   (i_exec_time),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_ran_id      (o_ran_id),
        .o_time_before (o_time_before),
        .o_completed   (o_completed),
        .o_live_count  (o_live_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            board.check_outcome('{o_status, o_ran_id, o_time_before, o_completed,
                                  o_live_count});
    end

    // watchdog: consecutive cycles with neither a transaction nor a result
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("round_robin_quantum_scheduler_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // holds start high until the block takes the transaction
    task automatic issue_item(input logic cmd, input logic [ID_W-1:0] pid,
                              input logic [TIME_W-1:0] exec_tm);
        start <= 1'b1;
        i_command <= cmd;
        i_proc_id <= pid;
        i_exec_time <= exec_tm;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_command(cmd, pid, exec_tm);
    endtask

    task automatic wait_idle();
        while (board.awaited_outcomes.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [TIME_W-1:0] q);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= q;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.quantum = q;
    endtask

    task automatic run_phase(input int n_items, input int add_pct);
        int                sent;
        int                burst;
        int                gap;
        int                span;
        logic              cmd;
        logic [TIME_W-1:0] exec_tm;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_RUN;
                // mostly times near the quantum so processes finish within a few rounds
                span = int'(board.quantum) * 4;
                if (span > 65535) span = 65535;
                case ($urandom_range(0, 19))
                    0, 1, 2:    exec_tm = TIME_W'($urandom_range(1, 65535));
                    3:          exec_tm = 16'd1;
                    4:          exec_tm = 16'hFFFF;
                    5:          exec_tm = board.quantum;
                    6:          exec_tm = (board.quantum == 16'hFFFF) ? board.quantum
                                                                      : board.quantum + 16'd1;
                    default:    exec_tm = TIME_W'($urandom_range(1, span));
                endcase
                issue_item(cmd, ID_W'($urandom), exec_tm);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;
    endtask

    initial begin
        int q;
        int add_pct;
        int waited;
        board = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        start <= 1'b0;
        i_command <= CMD_ADD;
        i_proc_id <= '0;
        i_exec_time <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty run, field extremes, fill to full, then a full add
        issue_item(CMD_RUN, 8'd0, 16'd0);
        issue_item(CMD_ADD, 8'd0, 16'd1);
        issue_item(CMD_ADD, 8'hFF, 16'hFFFF);
        issue_item(CMD_RUN, 8'd0, 16'd0);
        issue_item(CMD_RUN, 8'd0, 16'd0);
        issue_item(CMD_RUN, 8'd0, 16'd0);
        for (int i = 0; i < 15; i++) begin
            issue_item(CMD_ADD, (i % 2 == 0) ? ID_W'(8'hAA ^ i) : ID_W'(8'h55 ^ i),
                       (i % 3 == 0) ? 16'd1 : TIME_W'(i + 1));
        end
        issue_item(CMD_ADD, 8'h5A, 16'h8000);
        issue_item(CMD_RUN, 8'd0, 16'd0);

        // first random phase runs on the reset quantum
        run_phase(150, 45);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       begin q = 65535;                     add_pct = 70; end
                1:       begin q = 2;                         add_pct = 55; end
                2:       begin q = $urandom_range(3, 300);    add_pct = 50; end
                3:       begin q = 32768;                     add_pct = 60; end
                4:       begin q = $urandom_range(1, 65535);  add_pct = 50; end
                5:       begin q = 1;                         add_pct = 40; end
                default: begin q = $urandom_range(1, 16);     add_pct = 55; end
            endcase
            write_quantum(TIME_W'(q));
            run_phase(160, add_pct);
            wait_idle();
        end

        waited = 0;
        while (board.awaited_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (board.awaited_outcomes.size() != 0)
            board.report_mismatch($sformatf("%0d results never arrived",
                                            board.awaited_outcomes.size()));

        if (board.errors == 0) begin
            $display("round_robin_quantum_scheduler_tb: clean");
        end else begin
            $display("round_robin_quantum_scheduler_tb: errors");
        end
        $finish;
    end

endmodule
